@@ rtl/core/igbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igbt_pkg - shared types and constants of the box tracker
// Request codes, sequencer states and the compare unit's command struct.
// ----------------------------------------------------------------------------
package igbt_pkg;

    localparam int unsigned ID_BITS    = 32;
    localparam int unsigned LOST_BITS  = 9;
    localparam int unsigned ALIVE_BITS = 16;
    localparam int unsigned THR_BITS   = 16;
    localparam int unsigned MLOST_BITS = 8;
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam logic [LOST_BITS-1:0]  LOST_MAX  = '1;
    localparam logic [ALIVE_BITS-1:0] ALIVE_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IOU_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LOST_FRAMES = 1'd1;

    typedef enum logic [1:0] {
        T_REQ_BOX   = 2'd0,
        T_REQ_FRAME = 2'd1,
        T_REQ_CLEAR = 2'd2,
        T_REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_SLOT,
        S_M_RD,
        S_M_CMP,
        S_M_WAIT,
        S_M_THR,
        S_M_UPD,
        S_C_BOX,
        S_C_WR,
        S_E_SLOT,
        S_E_RD,
        S_E_OUT,
        S_E_EMPTY
    } t_state;

    // Request to the IoU unit: two rectangles, best so far, mode
    typedef struct packed {
        logic        start;
        logic        thr_mode;   // compare best against threshold
        logic [15:0] ax, ay, aw, ah;
        logic [15:0] bx, by, bw, bh;
        logic [63:0] best_in;
        logic [63:0] best_un;
        logic [THR_BITS-1:0] thr;
    } t_iou_cmd;

    typedef struct packed {
        logic        done;
        logic        hit;        // overlap nonzero
        logic        better;     // new > best, or threshold met
        logic [63:0] inter;
        logic [63:0] uni;
    } t_iou_rsp;

endpackage

@@ rtl/core/igbt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igbt_if - valid/ready channel
// Carries one request payload with a source and a sink view.
// ----------------------------------------------------------------------------
interface igbt_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/igbt_iou_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igbt_iou_unit - shared overlap and compare unit
// Computes intersection and union with a pair of 32x32
// multipliers, then compares against the best pair or the threshold by
// 128-bit cross products built from 32x32 partial products.
// ----------------------------------------------------------------------------
module igbt_iou_unit
    import igbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_iou_cmd i_cmd,
    output t_iou_rsp o_rsp
);
    typedef enum logic [3:0] {
        U_IDLE, U_EDGE, U_IA, U_AA, U_AB, U_UN,
        U_P1, U_P2, U_CMP, U_DONE
    } t_ustate;

    t_ustate     r_st, n_st;
    t_iou_cmd    r_cmd;
    logic [16:0] r_ix, r_iy;
    logic        r_hit;
    logic [63:0] r_in, r_un, r_aa;
    // cross product accumulators: lhs = X*Y, rhs = Z*W, each 128 bits
    logic [127:0] r_lhs, r_rhs;
    logic [1:0]   r_k;
    logic         r_better;

    logic [63:0] mx, my, mz, mw;
    logic [31:0] ma, mb;
    logic [63:0] mp;
    logic [16:0] ae, be, af, bf, ex, ey, sx, sy;

    // Select operands for the cross product: best mode or threshold mode
    always_comb begin
        if (r_cmd.thr_mode) begin
            mx = r_cmd.best_in; my = 64'd65536;
            mz = {48'd0, r_cmd.thr}; mw = r_cmd.best_un;
        end else begin
            mx = r_in; my = r_cmd.best_un;
            mz = r_cmd.best_in; mw = r_un;
        end
    end

    // Edge arithmetic
    always_comb begin
        ae = {1'b0, r_cmd.ax} + {1'b0, r_cmd.aw};
        be = {1'b0, r_cmd.bx} + {1'b0, r_cmd.bw};
        af = {1'b0, r_cmd.ay} + {1'b0, r_cmd.ah};
        bf = {1'b0, r_cmd.by} + {1'b0, r_cmd.bh};
        ex = (ae < be) ? ae : be;
        ey = (af < bf) ? af : bf;
        sx = {1'b0, (r_cmd.ax > r_cmd.bx) ? r_cmd.ax : r_cmd.bx};
        sy = {1'b0, (r_cmd.ay > r_cmd.by) ? r_cmd.ay : r_cmd.by};
    end

    // Shared multiplier operand select; U_P1/U_P2 step four partials
    logic [63:0] pa, pb;
    always_comb begin
        pa = r_k[1] ? mz : mx;
        pb = r_k[1] ? mw : my;
        ma = 32'd0;
        mb = 32'd0;
        case (r_st)
            U_IA:    begin ma = {15'd0, r_ix}; mb = {15'd0, r_iy}; end
            U_AA:    begin ma = {16'd0, r_cmd.aw}; mb = {16'd0, r_cmd.ah}; end
            U_AB:    begin ma = {16'd0, r_cmd.bw}; mb = {16'd0, r_cmd.bh}; end
            U_P1, U_P2: begin
                ma = r_k[0] ? pa[63:32] : pa[31:0];
                mb = pb[31:0];
            end
            default: begin ma = 32'd0; mb = 32'd0; end
        endcase
        mp = {32'd0, ma} * {32'd0, mb};
    end
    // second partial for the high word of the second operand
    logic [63:0] mp_h;
    assign mp_h = {32'd0, (r_k[0] ? pa[63:32] : pa[31:0])} * {32'd0, pb[63:32]};

    // Sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            U_IDLE: if (i_cmd.start) n_st = i_cmd.thr_mode ? U_P1 : U_EDGE;
            U_EDGE: n_st = U_IA;
            U_IA:   n_st = r_hit ? U_AA : U_DONE;
            U_AA:   n_st = U_AB;
            U_AB:   n_st = U_UN;
            U_UN:   n_st = U_P1;
            U_P1:   n_st = (r_k == 2'd3) ? U_CMP : U_P1;
            U_P2:   n_st = U_CMP;
            U_CMP:  n_st = U_DONE;
            U_DONE: n_st = U_IDLE;
            default: n_st = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= U_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            U_IDLE: begin
                r_cmd <= i_cmd;
                r_k   <= 2'd0;
                r_lhs <= '0;
                r_rhs <= '0;
                r_better <= 1'b0;
                r_hit <= i_cmd.thr_mode;
            end
            U_EDGE: begin
                r_hit <= (ex > sx) && (ey > sy);
                r_ix  <= ex - sx;
                r_iy  <= ey - sy;
            end
            U_IA: r_in <= mp;
            U_AA: r_aa <= mp;
            U_AB: r_un <= r_aa + mp;
            U_UN: r_un <= r_un - r_in;
            U_P1, U_P2: begin
                // accumulate a*b(lo) and a*b(hi) at the right offsets
                if (!r_k[1]) begin
                    r_lhs <= r_lhs + ({64'd0, mp} << (r_k[0] ? 32 : 0))
                                   + ({64'd0, mp_h} << (r_k[0] ? 64 : 32));
                end else begin
                    r_rhs <= r_rhs + ({64'd0, mp} << (r_k[0] ? 32 : 0))
                                   + ({64'd0, mp_h} << (r_k[0] ? 64 : 32));
                end
                r_k <= r_k + 2'd1;
            end
            U_CMP: r_better <= r_cmd.thr_mode ? (r_lhs >= r_rhs) : (r_lhs > r_rhs);
            default: ;
        endcase
    end

    assign o_rsp.done   = (r_st == U_DONE);
    assign o_rsp.hit    = r_hit;
    assign o_rsp.better = r_better;
    assign o_rsp.inter  = r_in;
    assign o_rsp.uni    = r_un;
endmodule

@@ rtl/core/iou_greedy_box_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_greedy_box_tracker_unit - IoU greedy box tracker
// Buffers boxes, matches them to tracks at frame end, opens new tracks and reports tracks.
//
//  channel  dir  payload                               accepted when
//  i_req    in   req_type, box_x/y/w/h                 valid & ready
//  o_trk    out  track_valid .. last (12 fields)       valid & ready
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data       i_cfg_we
//
// Box, clear and unused requests are each accepted in S_IDLE and can follow back to
// back. End of frame holds i_req.ready low while it walks: it compares each used
// track with every free box, checks a track's best candidate against the threshold,
// creates new tracks from unmatched boxes, then reports tracks and frees lost
// ones (shared IoU unit with two 32x32 multipliers).
// Synchronous active-low reset clears the slot table and counters.
// The sequencer stalls on o_trk.ready while a result waits.
// ----------------------------------------------------------------------------
module iou_greedy_box_tracker_unit
    import igbt_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = 32,
    parameter int unsigned MAX_BOXES  = 16,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    igbt_if.sink                     i_req,
    igbt_if.source                   o_trk,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int unsigned SB = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned BB = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CB = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic [15:0] x, y, w, h;
    } t_rect;

    // configuration
    logic [THR_BITS-1:0]   r_thr;
    logic [MLOST_BITS-1:0] r_mlost;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_BITS'(19661);
            r_mlost <= MLOST_BITS'(30);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IOU_THRESHOLD:   r_thr   <= i_cfg_data[THR_BITS-1:0];
                CFG_MAX_LOST_FRAMES: r_mlost <= i_cfg_data[MLOST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // memories
    t_rect               m_srect [MAX_TRACKS];
    logic [ID_BITS-1:0]  m_sid   [MAX_TRACKS];
    logic [LOST_BITS-1:0]  m_slost [MAX_TRACKS];
    logic [ALIVE_BITS-1:0] m_salive[MAX_TRACKS];
    t_rect               m_frect [MAX_BOXES];

    logic [MAX_TRACKS-1:0] r_used;
    logic [MAX_BOXES-1:0]  r_taken;
    logic [CB-1:0]         r_fcnt;
    logic [ID_BITS-1:0]    r_idc;
    logic                  r_drop;

    t_state r_st, n_st;
    logic [SB:0] r_s;
    logic [BB:0] r_b;
    logic [BB-1:0] r_bi;
    logic        r_found;
    logic [63:0] r_bin, r_bun;
    t_rect       r_tr, r_br;
    logic [ID_BITS-1:0]    r_tid;
    logic [LOST_BITS-1:0]  r_tlost;
    logic [ALIVE_BITS-1:0] r_talive;
    logic        r_any;
    logic        r_ovf;
    logic        r_busy;   // compare request issued, waiting

    t_iou_cmd cmd;
    t_iou_rsp rsp;

    igbt_iou_unit u_iou (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_rsp(rsp));

    logic [SB-1:0] s_i;
    logic [BB-1:0] b_i;
    assign s_i = r_s[SB-1:0];
    assign b_i = r_b[BB-1:0];

    logic s_end, b_end, b_live, later_used;
    assign s_end  = (r_s >= (SB+1)'(MAX_TRACKS));
    assign b_end  = (r_b >= (BB+1)'(r_fcnt));
    assign b_live = !b_end && !r_taken[b_i];
    // any used, unexpired slot after the current one (for last marking)
    always_comb begin
        later_used = 1'b0;
        for (int k = 0; k < MAX_TRACKS; k++) begin
            if ((SB+1)'(k) > r_s && r_used[k] &&
                m_slost[k] <= {1'b0, r_mlost}) later_used = 1'b1;
        end
    end

    // IoU request build
    always_comb begin
        cmd = '0;
        cmd.ax = r_tr.x; cmd.ay = r_tr.y; cmd.aw = r_tr.w; cmd.ah = r_tr.h;
        cmd.bx = r_br.x; cmd.by = r_br.y; cmd.bw = r_br.w; cmd.bh = r_br.h;
        cmd.best_in = r_bin;
        cmd.best_un = r_bun;
        cmd.thr     = r_thr;
        cmd.start   = (r_st == S_M_CMP || r_st == S_M_THR) && !r_busy;
        cmd.thr_mode = (r_st == S_M_THR);
    end

    logic in_acc;
    assign i_req.ready = (r_st == S_IDLE);
    assign in_acc = i_req.valid && i_req.ready;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (in_acc && t_req'(i_req.data.req_type) == T_REQ_FRAME)
                        n_st = S_M_SLOT;
            S_M_SLOT: begin
                if (s_end) n_st = S_C_BOX;
                else if (r_used[s_i]) n_st = S_M_RD;
            end
            S_M_RD:  n_st = b_end ? (r_found ? S_M_THR : S_M_UPD)
                                  : (b_live ? S_M_CMP : S_M_RD);
            S_M_CMP: if (rsp.done && r_busy) n_st = S_M_RD;
            S_M_THR: if (rsp.done && r_busy) n_st = S_M_UPD;
            S_M_UPD: n_st = S_M_SLOT;
            S_C_BOX: begin
                if (b_end) n_st = S_E_SLOT;
                else if (!r_taken[b_i] && free_ok) n_st = S_C_WR;
            end
            S_C_WR:  n_st = S_C_BOX;
            S_E_SLOT: begin
                if (s_end) n_st = r_any ? S_IDLE : S_E_EMPTY;
                else if (r_used[s_i]) n_st = S_E_RD;
            end
            S_E_RD: n_st = (r_tlost > {1'b0, r_mlost}) ? S_E_SLOT : S_E_OUT;
            S_E_OUT: if (o_trk.ready) n_st = S_E_SLOT;
            S_E_EMPTY: if (o_trk.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // free slot search for track creation
    logic [SB-1:0] free_s;
    logic          free_ok;
    always_comb begin
        free_s = '0;
        free_ok = 1'b0;
        for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_s = SB'(k);
                free_ok = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_taken <= '0; r_fcnt <= '0; r_idc <= '0;
            r_drop <= 1'b0; r_busy <= 1'b0; r_any <= 1'b0;
        end else begin
            r_busy <= cmd.start ? 1'b1 : (rsp.done ? 1'b0 : r_busy);
            case (r_st)
                S_IDLE: if (in_acc) begin
                    case (t_req'(i_req.data.req_type))
                        T_REQ_BOX: begin
                            if (r_fcnt < CB'(MAX_BOXES)) begin
                                r_taken[r_fcnt[BB-1:0]] <= 1'b0;
                                r_fcnt <= r_fcnt + 1'b1;
                            end else begin
                                r_drop <= 1'b1;
                            end
                        end
                        T_REQ_CLEAR: r_used <= '0;
                        default: ;
                    endcase
                    r_any <= 1'b0;
                end
                S_M_UPD: if (r_found && rsp.better) r_taken[r_bi] <= 1'b1;
                S_C_BOX: if (!b_end && !r_taken[b_i] && !free_ok) r_drop <= 1'b1;
                S_C_WR: begin
                    r_used[free_s] <= 1'b1;
                    r_idc <= r_idc + 1'b1;
                end
                S_E_RD: if (r_tlost > {1'b0, r_mlost}) r_used[s_i] <= 1'b0;
                S_E_OUT: if (o_trk.ready) r_any <= 1'b1;
                default: ;
            endcase
            if (r_st == S_E_SLOT && s_end) begin
                r_fcnt <= '0;
                r_taken <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    // payload, walkers and memories
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_s <= '0;
                r_b <= '0;
                r_found <= 1'b0;
                if (in_acc && t_req'(i_req.data.req_type) == T_REQ_BOX &&
                    r_fcnt < CB'(MAX_BOXES)) begin
                    m_frect[r_fcnt[BB-1:0]] <= '{
                        x: 16'(i_req.data.box_x[COORD_BITS-1:0]),
                        y: 16'(i_req.data.box_y[COORD_BITS-1:0]),
                        w: 16'(i_req.data.box_w[COORD_BITS-1:0]),
                        h: 16'(i_req.data.box_h[COORD_BITS-1:0])};
                end
            end
            S_M_SLOT: begin
                r_b <= '0;
                r_found <= 1'b0;
                r_bin <= '0;
                r_bun <= 64'd1;
                if (!s_end) begin
                    r_tr <= m_srect[s_i];
                    r_tlost <= m_slost[s_i];
                    r_talive <= m_salive[s_i];
                    if (!r_used[s_i]) r_s <= r_s + 1'b1;
                end
            end
            S_M_RD: begin
                if (!b_end) begin
                    r_br <= m_frect[b_i];
                    if (!b_live) r_b <= r_b + 1'b1;
                end
            end
            S_M_CMP: if (rsp.done && r_busy) begin
                if (rsp.hit && (!r_found || rsp.better)) begin
                    r_found <= 1'b1;
                    r_bi <= b_i;
                    r_bin <= rsp.inter;
                    r_bun <= rsp.uni;
                end
                r_b <= r_b + 1'b1;
            end
            S_M_UPD: begin
                if (r_found && rsp.better) begin
                    m_srect[s_i] <= m_frect[r_bi];
                    m_slost[s_i] <= '0;
                    m_salive[s_i] <= (r_talive == ALIVE_MAX) ? r_talive
                                                              : r_talive + 1'b1;
                end else if (r_tlost != LOST_MAX) begin
                    m_slost[s_i] <= r_tlost + 1'b1;
                end
                r_s <= r_s + 1'b1;
            end
            S_C_BOX: begin
                // hold the frame's overflow once every drop is known
                if (b_end) begin
                    r_s <= '0;
                    r_ovf <= r_drop;
                end else begin
                    r_br <= m_frect[b_i];
                    if (r_taken[b_i] || !free_ok) r_b <= r_b + 1'b1;
                end
            end
            S_C_WR: begin
                m_srect[free_s] <= r_br;
                m_sid[free_s] <= r_idc + 1'b1;
                m_slost[free_s] <= '0;
                m_salive[free_s] <= ALIVE_BITS'(1);
                r_b <= r_b + 1'b1;
            end
            S_E_SLOT: if (!s_end) begin
                r_tr <= m_srect[s_i];
                r_tid <= m_sid[s_i];
                r_tlost <= m_slost[s_i];
                r_talive <= m_salive[s_i];
                if (!r_used[s_i]) r_s <= r_s + 1'b1;
            end
            S_E_RD: if (r_tlost > {1'b0, r_mlost}) r_s <= r_s + 1'b1;
            S_E_OUT: if (o_trk.ready) r_s <= r_s + 1'b1;
            default: ;
        endcase
    end

    // result drive
    logic emp;
    assign emp = (r_st == S_E_EMPTY);
    assign o_trk.valid = (r_st == S_E_OUT) || emp;
    always_comb begin
        o_trk.data = '0;
        o_trk.data.overflow = r_ovf;
        if (emp) begin
            o_trk.data.last = 1'b1;
        end else begin
            o_trk.data.track_valid = 1'b1;
            o_trk.data.track_id    = r_tid;
            o_trk.data.track_x     = r_tr.x;
            o_trk.data.track_y     = r_tr.y;
            o_trk.data.track_w     = r_tr.w;
            o_trk.data.track_h     = r_tr.h;
            o_trk.data.center_x    = {1'b0, r_tr.x, 1'b0} + 18'(r_tr.w);
            o_trk.data.center_y    = {1'b0, r_tr.y, 1'b0} + 18'(r_tr.h);
            o_trk.data.lost_count  = r_tlost[7:0];
            o_trk.data.alive_count = r_talive;
            o_trk.data.last        = !later_used;
        end
    end
endmodule
